FILE: rtl/htcg_pkg.sv
package htcg_pkg;

  localparam int HEIGHT_W = 32;
  localparam int COLOR_W  = 24;
  localparam int CHAN_W   = 8;
  localparam int SPAN_W   = HEIGHT_W + 1;
  localparam int NUM_W    = HEIGHT_W + CHAN_W;
  localparam int Q_STEPS  = CHAN_W;
  localparam int CNT_W    = $clog2(Q_STEPS);

  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = {1'b0, {(HEIGHT_W-1){1'b1}}};
  localparam logic [HEIGHT_W-1:0] HEIGHT_MIN = {1'b1, {(HEIGHT_W-1){1'b0}}};
  localparam logic [CHAN_W-1:0]   CHAN_FULL  = {CHAN_W{1'b1}};

  // item functions
  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_ACCUM = 2'd1;
  localparam logic [1:0] FUNC_COLOR = 2'd2;

  // colour schemes, code three fades blue as well
  localparam logic [1:0] SCHEME_BLUE  = 2'd0;
  localparam logic [1:0] SCHEME_GREEN = 2'd1;
  localparam logic [1:0] SCHEME_RED   = 2'd2;

  // configuration register indexes
  localparam logic REG_COLOR_SCHEME = 1'b0;

  typedef struct packed {
    logic load;       // word accepted on the input channel
    logic prep;       // form span and offset of the latched height
    logic check;      // classify and seed the divider
    logic div_step;   // one quotient bit
    logic write_out;  // load the output register
  } htcg_cmd_t;

  typedef struct packed {
    logic skip;       // result needs no division
    logic out_free;   // output register can take a word
  } htcg_status_t;

endpackage

FILE: rtl/htcg_ctrl.sv
module htcg_ctrl
  import htcg_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic [1:0]   func,
  output logic         in_ready,
  input  htcg_status_t status,
  output htcg_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PREP  = 4'b0010,
    S_CHECK = 4'b0100,
    S_DIV   = 4'b1000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt;
  logic             done_phase;
  logic             done_phase_next;

  // final hand-off happens in idle-like wait, tracked separately
  assign in_ready = (state == S_IDLE) && !done_phase;

  always_comb begin
    cmd             = '0;
    state_next      = state;
    done_phase_next = done_phase;
    case (state)
      S_IDLE: begin
        if (done_phase) begin
          if (status.out_free) begin
            cmd.write_out   = 1'b1;
            done_phase_next = 1'b0;
          end
        end else if (in_valid) begin
          cmd.load = 1'b1;
          if (func == FUNC_COLOR) begin
            state_next = S_PREP;
          end
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (status.skip) begin
          state_next      = S_IDLE;
          done_phase_next = 1'b1;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == CNT_W'(Q_STEPS - 1)) begin
          state_next      = S_IDLE;
          done_phase_next = 1'b1;
        end
      end
      default: begin
        state_next      = S_IDLE;
        done_phase_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done_phase <= 1'b0;
      cnt        <= '0;
    end else begin
      state      <= state_next;
      done_phase <= done_phase_next;
      if (cmd.check) begin
        cnt <= '0;
      end else if (cmd.div_step) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  a_write_free: assert property (@(posedge clk) disable iff (rst)
    cmd.write_out |-> status.out_free)
    else $error("output written while occupied");

  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && cnt == CNT_W'(Q_STEPS - 1)) |=> (state == S_IDLE && done_phase))
    else $error("division did not end after its last step");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (state == S_IDLE && !done_phase))
    else $error("word accepted while busy");

endmodule

FILE: rtl/htcg_dp.sv
module htcg_dp
  import htcg_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  htcg_cmd_t           cmd,
  output htcg_status_t        status,
  input  logic [1:0]          color_scheme,
  input  logic [1:0]          func,
  input  logic [HEIGHT_W-1:0] height,
  input  logic                has_preset,
  input  logic [COLOR_W-1:0]  preset_color,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [COLOR_W-1:0]  rgb_color
);

  logic signed [HEIGHT_W-1:0] lowest, highest, h_r;
  logic                       preset_r;
  logic [COLOR_W-1:0]         preset_color_r;
  logic signed [SPAN_W-1:0]   span_r, diff_r;
  logic                       white_now, sat_now, white_r, sat_r;
  logic [NUM_W-1:0]           num;
  logic [HEIGHT_W-1:0]        rem;
  logic [CHAN_W-1:0]          nl, q;
  logic [SPAN_W-1:0]          trial, sub;
  logic                       ge;
  logic [CHAN_W-1:0]          c, nc;
  logic [COLOR_W-1:0]         color;

  // empty map, flat map or height at or below the minimum give white
  assign white_now = span_r[SPAN_W-1] || (span_r == '0) ||
                     diff_r[SPAN_W-1] || (diff_r == '0);
  assign sat_now   = (diff_r >= span_r);
  assign status.skip     = preset_r || white_now || sat_now;
  assign status.out_free = !out_valid || out_ready;

  // offset times 255 as a shift and subtract
  assign num = {diff_r[HEIGHT_W-1:0], CHAN_W'(0)} - {CHAN_W'(0), diff_r[HEIGHT_W-1:0]};

  assign trial = {rem, nl[CHAN_W-1]};
  assign sub   = trial - {1'b0, span_r[HEIGHT_W-1:0]};
  assign ge    = !sub[SPAN_W-1];

  assign c  = white_r ? '0 : (sat_r ? CHAN_FULL : q);
  assign nc = ~c;

  always_comb begin
    case (color_scheme)
      SCHEME_GREEN: color = {CHAN_FULL, nc, CHAN_FULL};
      SCHEME_RED:   color = {nc, CHAN_FULL, CHAN_FULL};
      default:      color = {CHAN_FULL, CHAN_FULL, nc};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lowest  <= HEIGHT_MAX;
      highest <= HEIGHT_MIN;
    end else if (cmd.load) begin
      if (func == FUNC_CLEAR) begin
        lowest  <= HEIGHT_MAX;
        highest <= HEIGHT_MIN;
      end else if (func == FUNC_ACCUM) begin
        if ($signed(height) < lowest) begin
          lowest <= height;
        end
        if ($signed(height) > highest) begin
          highest <= height;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      h_r            <= height;
      preset_r       <= has_preset;
      preset_color_r <= preset_color;
    end
    if (cmd.prep) begin
      span_r <= {highest[HEIGHT_W-1], highest} - {lowest[HEIGHT_W-1], lowest};
      diff_r <= {h_r[HEIGHT_W-1], h_r} - {lowest[HEIGHT_W-1], lowest};
    end
    if (cmd.check) begin
      white_r <= white_now;
      sat_r   <= sat_now;
      rem     <= num[NUM_W-1:CHAN_W];
      nl      <= num[CHAN_W-1:0];
      q       <= '0;
    end
    if (cmd.div_step) begin
      rem <= ge ? sub[HEIGHT_W-1:0] : trial[HEIGHT_W-1:0];
      nl  <= {nl[CHAN_W-2:0], 1'b0};
      q   <= {q[CHAN_W-2:0], ge};
    end
    if (cmd.write_out) begin
      rgb_color <= preset_r ? preset_color_r : color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.write_out || (out_valid && !out_ready);
    end
  end

  a_extrema_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.load |=> ($stable(lowest) && $stable(highest)))
    else $error("extrema changed without an input word");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (rem < span_r[HEIGHT_W-1:0]))
    else $error("partial remainder not below the span");

  a_quot_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.write_out && !preset_r && !white_r && !sat_r) |-> (q != CHAN_FULL))
    else $error("quotient reached full scale without saturation");

endmodule

FILE: rtl/height_to_color_gradient.sv
// height to colour gradient, min/max normalised colour map
// input channel (in_valid/in_ready) carries one word: func, height,
// has_preset, preset_color. func clear resets the running extrema, func
// accumulate folds height into the stored minimum and maximum, func colour
// gives one word on the output channel (out_valid/out_ready, rgb_color)
// clear and accumulate give no output word and leave the controller idle
// a colour word with a preset, or whose result is white or full scale,
// goes through prep and check straight to the hand-off; otherwise the
// 8-bit quotient comes from a restoring divider, one bit a cycle, before
// the hand-off, which waits for a free output register; the output word
// is shown the cycle after the controller hands it over
// the output register holds a finished word while the receiver stalls;
// a new word is taken then, and the next colour result waits for the slot
// the apb port holds color_scheme at byte address 0, pready is always high
// synchronous reset clears the extrema to the empty map, the scheme to blue
// and the output register to empty
module height_to_color_gradient
  import htcg_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          func,
  input  logic [HEIGHT_W-1:0] height,
  input  logic                has_preset,
  input  logic [COLOR_W-1:0]  preset_color,
  // output channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [COLOR_W-1:0]  rgb_color,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  htcg_cmd_t    cmd;
  htcg_status_t status;
  logic [1:0]   color_scheme;
  logic         reg_sel;

  // word index of the register, byte lanes ignored
  assign reg_sel = paddr[2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_scheme <= SCHEME_BLUE;
    end else if (psel && penable && pwrite && pready && reg_sel == REG_COLOR_SCHEME) begin
      color_scheme <= pwdata[1:0];
    end
  end

  // reads of unmapped addresses return zero
  assign prdata = (reg_sel == REG_COLOR_SCHEME) ? {30'd0, color_scheme} : 32'd0;

  // sequencing of one word at a time
  htcg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .func     (func),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // extrema, span, divider and output register
  htcg_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .color_scheme (color_scheme),
    .func         (func),
    .height       (height),
    .has_preset   (has_preset),
    .preset_color (preset_color),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .rgb_color    (rgb_color)
  );

endmodule

FILE: tb/height_to_color_gradient_test.sv
`timescale 1ns / 100ps

module height_to_color_gradient_test
  import htcg_pkg::*;
();

  // func code that the block ignores
  localparam logic [1:0] FUNC_NONE = 2'd3;
  // scheme code three, handled as blue
  localparam logic [1:0] SCHEME_THREE = 2'd3;
  // cycles without any accepted word before the run is called hung
  localparam int STALL_LIMIT = 5000;
  // settling time after the last colour word, longer than a division
  localparam int SETTLE_CYCLES = 24;
  // receiver hold-off, long enough to back the block up to its input
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [1:0]                 fn;
    logic signed [HEIGHT_W-1:0] h;
    logic                       pre;
    logic [COLOR_W-1:0]         pc;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          func = FUNC_CLEAR;
  logic [HEIGHT_W-1:0] height = '0;
  logic                has_preset = 1'b0;
  logic [COLOR_W-1:0]  preset_color = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [COLOR_W-1:0]  rgb_color;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  // words waiting for the driver, and colours still owed by the block
  point_t             waiting[$];
  point_t             on_wire;
  logic [COLOR_W-1:0] colour_due[$];

  // shadow of the block's extrema and scheme
  logic signed [HEIGHT_W-1:0] map_low = HEIGHT_MAX;
  logic signed [HEIGHT_W-1:0] map_high = HEIGHT_MIN;
  logic [1:0]                 scheme_now = SCHEME_BLUE;

  int faults = 0;
  int idle_run = 0;
  int hold_left = 0;
  logic hold_go = 1'b0;
  logic hold_taken = 1'b0;
  logic quiet = 1'b0;

  height_to_color_gradient u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .height       (height),
    .has_preset   (has_preset),
    .preset_color (preset_color),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .rgb_color    (rgb_color),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #4 clk = ~clk;

  // expected colour of one point from the shadow extrema
  function automatic logic [COLOR_W-1:0] shade_of(logic signed [HEIGHT_W-1:0] h);
    longint span;
    longint num;
    longint quo;
    logic [CHAN_W-1:0] c;
    span = longint'(map_high) - longint'(map_low);
    // flat map, or nothing accumulated yet
    if (span <= 0) return {COLOR_W{1'b1}};
    num = (longint'(h) - longint'(map_low)) * 255;
    // below the minimum clamps to zero, above the maximum to full scale
    if (num <= 0) quo = 0;
    else quo = num / span;
    if (quo > 255) quo = 255;
    c = quo[CHAN_W-1:0];
    case (scheme_now)
      SCHEME_GREEN: return {CHAN_FULL, CHAN_FULL - c, CHAN_FULL};
      SCHEME_RED:   return {CHAN_FULL - c, CHAN_FULL, CHAN_FULL};
      // scheme three fades blue too
      default:      return {CHAN_FULL, CHAN_FULL, CHAN_FULL - c};
    endcase
  endfunction

  // fold one accepted word into the shadow state
  task automatic take_word(point_t p);
    case (p.fn)
      FUNC_CLEAR: begin
        map_low = HEIGHT_MAX;
        map_high = HEIGHT_MIN;
      end
      FUNC_ACCUM: begin
        if (p.h < map_low) map_low = p.h;
        if (p.h > map_high) map_high = p.h;
      end
      FUNC_COLOR: begin
        // a preset colour passes straight through
        colour_due.push_back(p.pre ? p.pc : shade_of(p.h));
      end
      default: begin
      end
    endcase
  endtask

  // driver: a word stays on the wire until it is taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) take_word(on_wire);
      if (!in_valid || in_ready) begin
        if (waiting.size() != 0 && (quiet || $urandom_range(0, 99) >= 23)) begin
          on_wire = waiting.pop_front();
          in_valid <= 1'b1;
          func <= on_wire.fn;
          height <= on_wire.h;
          has_preset <= on_wire.pre;
          preset_color <= on_wire.pc;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each colour word with the oldest one owed
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (colour_due.size() == 0) begin
          $display("%0t: rgb_color expected none got %06h", $time, rgb_color);
          faults++;
        end else if (rgb_color !== colour_due[0]) begin
          $display("%0t: rgb_color expected %06h got %06h", $time, colour_due[0],
                   rgb_color);
          faults++;
          void'(colour_due.pop_front());
        end else begin
          void'(colour_due.pop_front());
        end
      end
      // one long hold-off, counted here, so the block backs up
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (hold_go && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet || ($urandom_range(0, 99) >= 23);
      end
    end
  end

  // watchdog on cycles with nothing accepted anywhere
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      idle_run <= 0;
    end else if (idle_run >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  task automatic queue_point(logic [1:0] fn, logic [HEIGHT_W-1:0] h, logic pre,
                             logic [COLOR_W-1:0] pc);
    point_t p;
    p.fn = fn;
    p.h = h;
    p.pre = pre;
    p.pc = pc;
    waiting.push_back(p);
  endtask

  // wait until every word is taken and every colour is back, then let
  // any clear or accumulate still in flight finish
  task automatic settle();
    while (waiting.size() != 0 || in_valid || colour_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write of the colour scheme, only while the block is idle
  task automatic write_scheme(logic [1:0] code);
    logic [31:0] word;
    word = {$urandom} & 32'hFFFF_FFFC;
    word[1:0] = code;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_COLOR_SCHEME, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    scheme_now = code;
  endtask

  // heights mostly clustered round a base, now and then anywhere
  function automatic logic [HEIGHT_W-1:0] pick_height(logic [HEIGHT_W-1:0] base,
                                                      logic [31:0] spread);
    case ($urandom_range(0, 19))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? HEIGHT_MAX : HEIGHT_MIN;
      default: return base + ($urandom % (spread + 1)) - (spread >> 1);
    endcase
  endfunction

  // one phase of random traffic: mostly clear, accumulate, colour runs
  task automatic fill_phase(int count);
    int done;
    int n;
    logic [HEIGHT_W-1:0] base;
    logic [31:0] spread;
    done = 0;
    while (done < count) begin
      if ($urandom_range(0, 99) < 85) begin
        base = $urandom;
        case ($urandom_range(0, 5))
          0: spread = 0;
          1: spread = 1;
          2: spread = 255;
          3: spread = $urandom_range(2, 5000);
          4: spread = $urandom_range(0, 1 << 20);
          default: spread = 32'h7FFF_FFFF;
        endcase
        // sometimes keep the old extrema and widen them
        if ($urandom_range(0, 4) != 0) begin
          queue_point(FUNC_CLEAR, $urandom, 1'($urandom_range(0, 1)),
                      COLOR_W'($urandom));
          done++;
        end
        n = $urandom_range(1, 6);
        repeat (n) queue_point(FUNC_ACCUM, pick_height(base, spread),
                               1'($urandom_range(0, 1)), COLOR_W'($urandom));
        done += n;
        n = $urandom_range(2, 10);
        repeat (n) begin
          if ($urandom_range(0, 99) < 15)
            queue_point(FUNC_COLOR, $urandom, 1'b1, COLOR_W'($urandom));
          else
            queue_point(FUNC_COLOR, pick_height(base, spread), 1'b0,
                        COLOR_W'($urandom));
        end
        done += n;
      end else begin
        // noise: any func, any field
        n = $urandom_range(0, 3);
        queue_point(n[1:0], $urandom, 1'($urandom_range(0, 1)), COLOR_W'($urandom));
        if (n[1:0] != FUNC_NONE) done++;
      end
    end
  endtask

  initial begin
    logic [1:0] plan[10];
    plan = '{SCHEME_GREEN, SCHEME_RED, SCHEME_THREE, SCHEME_BLUE, SCHEME_RED,
             SCHEME_GREEN, SCHEME_THREE, SCHEME_BLUE, SCHEME_RED, SCHEME_GREEN};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty map, presets, ignored func
    queue_point(FUNC_COLOR, 32'd0, 1'b0, 24'h123456);
    queue_point(FUNC_COLOR, 32'd7, 1'b1, 24'hABCDEF);
    queue_point(FUNC_COLOR, HEIGHT_MIN, 1'b1, 24'h000000);
    queue_point(FUNC_COLOR, HEIGHT_MAX, 1'b1, 24'hFFFFFF);
    queue_point(FUNC_NONE, 32'hFFFF_FFFF, 1'b1, 24'hFFFFFF);
    // flat map gives white
    queue_point(FUNC_ACCUM, 32'd100, 1'b0, 24'h0);
    queue_point(FUNC_COLOR, 32'd100, 1'b0, 24'hFFFFFF);
    // full signed range
    queue_point(FUNC_ACCUM, HEIGHT_MIN, 1'b1, 24'hFFFFFF);
    queue_point(FUNC_ACCUM, HEIGHT_MAX, 1'b0, 24'h0);
    queue_point(FUNC_COLOR, HEIGHT_MIN, 1'b0, 24'h0);
    queue_point(FUNC_COLOR, HEIGHT_MAX, 1'b0, 24'h0);
    queue_point(FUNC_COLOR, 32'd0, 1'b0, 24'hFFFFFF);
    queue_point(FUNC_COLOR, 32'd1, 1'b0, 24'h5A5A5A);
    queue_point(FUNC_COLOR, 32'hFFFF_FFFF, 1'b0, 24'h0);
    // narrow map, below and above its bounds
    queue_point(FUNC_CLEAR, 32'hDEAD_BEEF, 1'b1, 24'hFFFFFF);
    queue_point(FUNC_COLOR, 32'd3, 1'b0, 24'h0);
    queue_point(FUNC_ACCUM, 32'd50, 1'b0, 24'h0);
    queue_point(FUNC_ACCUM, 32'd10, 1'b0, 24'h0);
    queue_point(FUNC_COLOR, 32'd5, 1'b0, 24'h0);
    queue_point(FUNC_COLOR, 32'd60, 1'b0, 24'h0);
    queue_point(FUNC_COLOR, 32'd30, 1'b0, 24'h0);
    queue_point(FUNC_COLOR, 32'd49, 1'b0, 24'h0);
    queue_point(FUNC_COLOR, 32'd30, 1'b1, 24'h00FF00);
    queue_point(FUNC_NONE, 32'd30, 1'b0, 24'h0);
    settle();

    // random phases, one scheme each
    foreach (plan[i]) begin
      write_scheme(plan[i]);
      if (i == 2) hold_go <= 1'b1;
      // a phase with no idling on either side
      quiet <= (i == 4);
      fill_phase(53);
      settle();
    end

    if (faults == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
